// ===== design/eabv_pkg.sv =====
// package for the euler angles to basis vectors block
// constants, cordic arctangent table and fixed point helpers; no dependencies
package eabv_pkg;

   localparam int ANGLE_BITS    = 16;
   localparam int OUT_FRAC_BITS = 14;
   localparam int CORDIC_STAGES = 16;
   localparam int WORK_FRAC     = 30;
   localparam int OUT_BITS      = 16;
   localparam int W             = 34;
   localparam logic signed [W-1:0] CORDIC_GAIN = W'(652032874);

   typedef logic signed [W-1:0] work_type;

   typedef struct packed {
      logic [1:0] quad;
      work_type   x;
      work_type   y;
      work_type   z;
   } cordic_type;

   function automatic work_type atan_turn(input int i);
      logic [31:0] t [32];
      t = '{32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756, 32'd42667331,
            32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
            32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
            32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
            32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};
      return work_type'({2'b00, t[i]});
   endfunction

   // q30 product rounded to nearest, ties upward
   function automatic work_type qmul(input work_type a, input work_type b);
      logic signed [2*W-1:0] p;
      p = a * b + (2*W)'(64'sd1 <<< (WORK_FRAC - 1));
      return work_type'(p >>> WORK_FRAC);
   endfunction

   function automatic logic signed [OUT_BITS-1:0] to_out(input work_type v);
      localparam int SH = WORK_FRAC - OUT_FRAC_BITS;
      localparam logic signed [W-1:0] LIM = W'(64'sd1 <<< OUT_FRAC_BITS);
      work_type r;
      r = (v + W'(64'sd1 <<< (SH - 1))) >>> SH;
      if (r > LIM) r = LIM;
      if (r < -LIM) r = -LIM;
      return r[OUT_BITS-1:0];
   endfunction

endpackage

// ===== design/eabv_cordic_cell.sv =====
// one cordic micro-rotation cell, registered
// depends on eabv_pkg
module eabv_cordic_cell import eabv_pkg::*; (
   input  logic       clock,
   input  logic [4:0] stage,
   input  cordic_type din,
   output cordic_type dout
);
   cordic_type dout_ff, dout_in;
   work_type xs, ys;

   always_comb begin
      xs = din.x >>> stage;
      ys = din.y >>> stage;
      dout_in = din;
      if (!din.z[W-1]) begin
         dout_in.x = din.x - ys;
         dout_in.y = din.y + xs;
         dout_in.z = din.z - atan_turn(int'(stage));
      end else begin
         dout_in.x = din.x + ys;
         dout_in.y = din.y - xs;
         dout_in.z = din.z + atan_turn(int'(stage));
      end
   end

   always_ff @(posedge clock) begin
      dout_ff <= dout_in;
   end

   assign dout = dout_ff;
endmodule

// ===== design/eabv_sincos.sv =====
// chain of cordic cells giving cosine and sine of one binary angle
// depends on eabv_pkg and eabv_cordic_cell
module eabv_sincos import eabv_pkg::*; (
   input  logic                  clock,
   input  logic [ANGLE_BITS-1:0] angle,
   output work_type              cos_out,
   output work_type              sin_out
);
   cordic_type chain [CORDIC_STAGES+1];
   logic [31:0] turn;

   assign turn = {angle, {(32-ANGLE_BITS){1'b0}}};
   assign chain[0].quad = turn[31:30];
   assign chain[0].x = CORDIC_GAIN;
   assign chain[0].y = '0;
   assign chain[0].z = work_type'({4'b0000, turn[29:0]});

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      eabv_cordic_cell u_cell (
         .clock(clock),
         .stage(5'(i)),
         .din  (chain[i]),
         .dout (chain[i+1])
      );
   end

   cordic_type last;
   work_type cos_ff, sin_ff, cos_in, sin_in;
   assign last = chain[CORDIC_STAGES];

   always_comb begin
      case (last.quad)
         2'd0: begin cos_in = last.x;  sin_in = last.y;  end
         2'd1: begin cos_in = -last.y; sin_in = last.x;  end
         2'd2: begin cos_in = -last.x; sin_in = -last.y; end
         default: begin cos_in = last.y; sin_in = -last.x; end
      endcase
   end

   always_ff @(posedge clock) begin
      cos_ff <= cos_in;
      sin_ff <= sin_in;
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;
endmodule

// ===== design/euler_angles_to_basis_vectors_top.sv =====
// top level: three sine/cosine chains feeding a three-stage product pipeline
// depends on eabv_pkg and eabv_sincos
//
// takes one angle triple per cycle whenever start is high (busy is always low);
// each result appears for one cycle with rsp_valid after passing the
// sixteen-cell cordic chain plus one quadrant, two product and one output
// stage. the receiver cannot stall; csr_we changes the layout and should be
// written with no word in flight
module euler_angles_to_basis_vectors_top import eabv_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [15:0] req_pitch_angle,
   input  logic [15:0] req_yaw_angle,
   input  logic [15:0] req_roll_angle,
   input  logic csr_we,
   input  logic csr_wdata,
   output logic rsp_valid,
   output logic signed [15:0] rsp_forward_x,
   output logic signed [15:0] rsp_forward_y,
   output logic signed [15:0] rsp_forward_z,
   output logic signed [15:0] rsp_right_x,
   output logic signed [15:0] rsp_right_y,
   output logic signed [15:0] rsp_right_z,
   output logic signed [15:0] rsp_up_x,
   output logic signed [15:0] rsp_up_y,
   output logic signed [15:0] rsp_up_z
);
   localparam int LAT = CORDIC_STAGES + 4;

   logic transposed_ff;
   logic [LAT-1:0] valid_ff;
   work_type cp, sp, cy, sy, cr, sr;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         transposed_ff <= 1'b0;
         valid_ff <= '0;
      end else begin
         if (csr_we) transposed_ff <= csr_wdata;
         valid_ff <= {valid_ff[LAT-2:0], start};
      end
   end

   eabv_sincos u_pitch (.clock(clock), .angle(req_pitch_angle[ANGLE_BITS-1:0]),
                        .cos_out(cp), .sin_out(sp));
   eabv_sincos u_yaw   (.clock(clock), .angle(req_yaw_angle[ANGLE_BITS-1:0]),
                        .cos_out(cy), .sin_out(sy));
   eabv_sincos u_roll  (.clock(clock), .angle(req_roll_angle[ANGLE_BITS-1:0]),
                        .cos_out(cr), .sin_out(sr));

   // stage a: two-term products
   work_type srsp_ff, crsp_ff, cpcy_ff, cpsy_ff, nsp_ff, crsy_ff, crcy_ff;
   work_type srcp_ff, srsy_ff, srcy_ff, crcp_ff, cy_ff, sy_ff;
   always_ff @(posedge clock) begin
      srsp_ff <= qmul(sr, sp);
      crsp_ff <= qmul(cr, sp);
      cpcy_ff <= qmul(cp, cy);
      cpsy_ff <= qmul(cp, sy);
      nsp_ff  <= -sp;
      crsy_ff <= qmul(cr, sy);
      crcy_ff <= qmul(cr, cy);
      srcp_ff <= qmul(sr, cp);
      srsy_ff <= qmul(sr, sy);
      srcy_ff <= qmul(sr, cy);
      crcp_ff <= qmul(cr, cp);
      cy_ff   <= cy;
      sy_ff   <= sy;
   end

   // stage b: third term and output rounding
   logic signed [OUT_BITS-1:0] m_ff [9];
   always_ff @(posedge clock) begin
      m_ff[0] <= to_out(cpcy_ff);
      m_ff[1] <= to_out(cpsy_ff);
      m_ff[2] <= to_out(nsp_ff);
      m_ff[3] <= to_out(qmul(srsp_ff, cy_ff) - crsy_ff);
      m_ff[4] <= to_out(qmul(srsp_ff, sy_ff) + crcy_ff);
      m_ff[5] <= to_out(srcp_ff);
      m_ff[6] <= to_out(qmul(crsp_ff, cy_ff) + srsy_ff);
      m_ff[7] <= to_out(qmul(crsp_ff, sy_ff) - srcy_ff);
      m_ff[8] <= to_out(crcp_ff);
   end

   // stage c: layout select
   logic signed [OUT_BITS-1:0] o_ff [9];
   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (transposed_ff) o_ff[r*3+c] <= m_ff[c*3+r];
            else if (r == 1) o_ff[r*3+c] <= -m_ff[r*3+c];
            else o_ff[r*3+c] <= m_ff[r*3+c];
         end
      end
   end

   assign rsp_valid = valid_ff[LAT-1];
   assign rsp_forward_x = o_ff[0];
   assign rsp_forward_y = o_ff[1];
   assign rsp_forward_z = o_ff[2];
   assign rsp_right_x = o_ff[3];
   assign rsp_right_y = o_ff[4];
   assign rsp_right_z = o_ff[5];
   assign rsp_up_x = o_ff[6];
   assign rsp_up_y = o_ff[7];
   assign rsp_up_z = o_ff[8];
endmodule

// ===== verif/euler_angles_to_basis_vectors_top_test.sv =====
// testbench for euler_angles_to_basis_vectors_top: drives angle triples and checks each
// basis word against a cordic based predictor; depends on eabv_pkg and the design files
module euler_angles_to_basis_vectors_top_test;
   import eabv_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [8:0][15:0] basis_word_type;

   localparam longint ATAN_TURNS [16] = '{536870912, 316933405, 167458907, 85004756,
      42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861};
   localparam int STALL_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [15:0] req_pitch_angle = '0;
   logic [15:0] req_yaw_angle = '0;
   logic [15:0] req_roll_angle = '0;
   logic csr_we = 1'b0;
   logic csr_wdata = 1'b0;
   logic rsp_valid;
   logic signed [15:0] rsp_forward_x, rsp_forward_y, rsp_forward_z;
   logic signed [15:0] rsp_right_x, rsp_right_y, rsp_right_z;
   logic signed [15:0] rsp_up_x, rsp_up_y, rsp_up_z;

   basis_word_type expected_basis [$];
   logic transposed = 1'b0;
   bit steady = 1'b0;
   int errors = 0;
   int quiet_cycles = 0;

   euler_angles_to_basis_vectors_top DUT (.*);

   always #2 clock = ~clock;

   function automatic void angle_sin_cos(input logic [15:0] a, output longint c,
                                         output longint s);
      logic [31:0] turn;
      longint x, y, z, xs, ys;
      turn = {a, 16'h0};
      x = 652032874;
      y = 0;
      z = longint'(turn[29:0]);
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= ATAN_TURNS[i];
         end else begin
            x += ys; y -= xs; z += ATAN_TURNS[i];
         end
      end
      case (turn[31:30])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic longint mul_q30(input longint a, input longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic logic [15:0] q30_to_q14(input longint v);
      longint r;
      r = (v + (64'sd1 <<< 15)) >>> 16;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r[15:0];
   endfunction

   function automatic basis_word_type predict_basis(input logic [15:0] p,
                                                    input logic [15:0] yw,
                                                    input logic [15:0] rl, input logic tr);
      longint cp, sp, cy, sy, cr, sr, srsp, crsp;
      logic [15:0] m [3][3];
      basis_word_type b;
      angle_sin_cos(p, cp, sp);
      angle_sin_cos(yw, cy, sy);
      angle_sin_cos(rl, cr, sr);
      srsp = mul_q30(sr, sp);
      crsp = mul_q30(cr, sp);
      m[0][0] = q30_to_q14(mul_q30(cp, cy));
      m[0][1] = q30_to_q14(mul_q30(cp, sy));
      m[0][2] = q30_to_q14(-sp);
      m[1][0] = q30_to_q14(mul_q30(srsp, cy) - mul_q30(cr, sy));
      m[1][1] = q30_to_q14(mul_q30(srsp, sy) + mul_q30(cr, cy));
      m[1][2] = q30_to_q14(mul_q30(sr, cp));
      m[2][0] = q30_to_q14(mul_q30(crsp, cy) + mul_q30(sr, sy));
      m[2][1] = q30_to_q14(mul_q30(crsp, sy) - mul_q30(sr, cy));
      m[2][2] = q30_to_q14(mul_q30(cr, cp));
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            if (tr) b[r*3+c] = m[c][r];
            else if (r == 1) b[r*3+c] = -m[r][c];
            else b[r*3+c] = m[r][c];
      return b;
   endfunction

   // accepted words become expectations
   always @(posedge clock) begin
      if (!reset && start && !busy)
         expected_basis.push_back(predict_basis(req_pitch_angle, req_yaw_angle,
                                                req_roll_angle, transposed));
   end

   always @(posedge clock) begin
      basis_word_type got, want;
      if (!reset && rsp_valid) begin
         got = {rsp_up_z, rsp_up_y, rsp_up_x, rsp_right_z, rsp_right_y, rsp_right_x,
                rsp_forward_z, rsp_forward_y, rsp_forward_x};
         if (expected_basis.size() == 0) begin
            errors++;
            $display("%t unexpected word %h", $realtime, got);
         end else begin
            want = expected_basis.pop_front();
            for (int i = 0; i < 9; i++)
               if (got[i] !== want[i]) begin
                  errors++;
                  $display("%t component %0d expected %0d actual %0d", $realtime, i,
                           $signed(want[i]), $signed(got[i]));
               end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_angles(input logic [15:0] p, input logic [15:0] yw,
                              input logic [15:0] rl);
      int gap;
      start <= 1'b1;
      req_pitch_angle <= p;
      req_yaw_angle <= yw;
      req_roll_angle <= rl;
      do @(posedge clock); while (busy);
      gap = steady ? 0 : ($urandom_range(0, 9) < 6 ? 0 :
            ($urandom_range(0, 9) < 8 ? int'($urandom_range(1, 3)) :
             int'($urandom_range(10, 40))));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_words();
      start <= 1'b0;
      @(posedge clock);
      while (expected_basis.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_layout(input logic v);
      drain_words();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      transposed = v;
      csr_we <= 1'b0;
   endtask

   task automatic test_directed_angles();
      logic [15:0] marks [8] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000,
                                 16'h2000, 16'h0001, 16'h7FFF};
      for (int l = 0; l < 2; l++) begin
         write_layout(l[0]);
         for (int i = 0; i < 8; i++)
            send_angles(marks[i], marks[(i + 3) % 8], marks[(i + 5) % 8]);
         send_angles(16'hAAAA, 16'h5555, 16'hFFFF);
      end
   endtask

   task automatic test_random_angles();
      for (int phase = 0; phase < 7; phase++) begin
         write_layout(1'($urandom_range(0, 1)));
         steady = (phase == 2 || phase == 5);
         for (int i = 0; i < 100; i++)
            send_angles(16'($urandom), 16'($urandom), 16'($urandom));
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_angles();
      test_random_angles();
      drain_words();
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule

// ===== filelist.f =====
design/eabv_pkg.sv
design/eabv_cordic_cell.sv
design/eabv_sincos.sv
design/euler_angles_to_basis_vectors_top.sv
verif/euler_angles_to_basis_vectors_top_test.sv
